FILE: design/lmc_pkg.sv
// Shared types and constants for the light mode classifier.
// Register map codes, mode codes, configuration and result structs.
// No dependencies.
package lmc_pkg;

  localparam int CFG_IDX_BITS = 3;
  localparam int TH_BITS      = 16;
  localparam int BYTE_BITS    = 8;

  localparam logic [BYTE_BITS-1:0] RST_MARGIN  = 8'd100;
  localparam logic [BYTE_BITS-1:0] RST_CONFIRM = 8'd1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DAY_TH       = 3'd0,
    REG_NIGHT_TH     = 3'd1,
    REG_MARGIN       = 3'd2,
    REG_CONFIRM      = 3'd3,
    REG_BRIGHT_DAY   = 3'd4,
    REG_BRIGHT_MID   = 3'd5,
    REG_BRIGHT_NIGHT = 3'd6
  } lmc_reg_t;

  typedef enum logic [1:0] {
    MODE_INVALID = 2'd0,
    MODE_NIGHT   = 2'd1,
    MODE_MIDDLE  = 2'd2,
    MODE_DAY     = 2'd3
  } lmc_mode_t;

  typedef struct packed {
    logic signed [TH_BITS-1:0] day_th;
    logic signed [TH_BITS-1:0] night_th;
    logic [BYTE_BITS-1:0]      margin;
    logic [BYTE_BITS-1:0]      confirm;
    logic [BYTE_BITS-1:0]      bright_day;
    logic [BYTE_BITS-1:0]      bright_mid;
    logic [BYTE_BITS-1:0]      bright_night;
  } lmc_cfg_t;

  typedef struct packed {
    lmc_mode_t            mode;
    logic                 changed;
    logic                 bwr;
    logic [BYTE_BITS-1:0] bval;
  } lmc_result_t;

endpackage

FILE: design/lmc_in_if.sv
// Sample input channel: valid/ready handshake with one signed light sample.
// Depends on nothing.
interface lmc_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] light_sample;

  modport source (output valid, output light_sample, input ready);
  modport sink   (input valid, input light_sample, output ready);
endinterface

FILE: design/lmc_out_if.sv
// Result channel: valid/ready handshake with mode, change flag and brightness write.
// Depends on nothing.
interface lmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] light_mode;
  logic       mode_changed;
  logic       brightness_write;
  logic [7:0] brightness_value;

  modport source (output valid, output light_mode, output mode_changed,
                  output brightness_write, output brightness_value, input ready);
  modport sink   (input valid, input light_mode, input mode_changed,
                  input brightness_write, input brightness_value, output ready);
endinterface

FILE: design/lmc_cfg_if.sv
// Configuration write channel: valid/ready handshake, register index and data.
// Depends on nothing.
interface lmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/lmc_cfg_regs.sv
// Configuration register file for the light mode classifier.
// Depends on lmc_pkg and lmc_cfg_if.
module lmc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  lmc_cfg_if.sink           cfg_s,
  output lmc_pkg::lmc_cfg_t cfg
);
  import lmc_pkg::*;

  lmc_cfg_t cfg_r;
  lmc_cfg_t cfg_nxt;

  assign cfg_s.ready = 1'b1;
  assign cfg         = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_s.valid) begin
      case (lmc_reg_t'(cfg_s.index))
        REG_DAY_TH:       cfg_nxt.day_th       = cfg_s.data;
        REG_NIGHT_TH:     cfg_nxt.night_th     = cfg_s.data;
        REG_MARGIN:       cfg_nxt.margin       = cfg_s.data[BYTE_BITS-1:0];
        REG_CONFIRM:      cfg_nxt.confirm      = cfg_s.data[BYTE_BITS-1:0];
        REG_BRIGHT_DAY:   cfg_nxt.bright_day   = cfg_s.data[BYTE_BITS-1:0];
        REG_BRIGHT_MID:   cfg_nxt.bright_mid   = cfg_s.data[BYTE_BITS-1:0];
        REG_BRIGHT_NIGHT: cfg_nxt.bright_night = cfg_s.data[BYTE_BITS-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.day_th       <= '0;
      cfg_r.night_th     <= '0;
      cfg_r.margin       <= RST_MARGIN;
      cfg_r.confirm      <= RST_CONFIRM;
      cfg_r.bright_day   <= '0;
      cfg_r.bright_mid   <= '0;
      cfg_r.bright_night <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: design/lmc_zone_tracker.sv
// Zone classification, debounce run counters and current mode register.
// Depends on lmc_pkg.
module lmc_zone_tracker #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  lmc_pkg::lmc_cfg_t             cfg,
  output lmc_pkg::lmc_result_t          res
);
  import lmc_pkg::*;

  localparam int CW = ((SAMPLE_BITS > TH_BITS) ? SAMPLE_BITS : TH_BITS) + 2;

  logic [BYTE_BITS-1:0] day_run_r, mid_run_r, night_run_r;
  logic [BYTE_BITS-1:0] day_run_nxt, mid_run_nxt, night_run_nxt;
  lmc_mode_t            mode_r, mode_nxt;

  logic signed [CW-1:0] s_w, dth_w, nth_w, m_w, mid_lo, mid_hi;
  logic                 is_day, is_mid, is_night;
  logic [BYTE_BITS:0]   day_inc, mid_inc, night_inc, conf_w;
  logic                 day_hit, mid_hit, night_hit;
  logic                 bwr;
  logic [BYTE_BITS-1:0] bval;

  assign s_w    = {{(CW-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
  assign dth_w  = {{(CW-TH_BITS){cfg.day_th[TH_BITS-1]}}, cfg.day_th};
  assign nth_w  = {{(CW-TH_BITS){cfg.night_th[TH_BITS-1]}}, cfg.night_th};
  assign m_w    = {{(CW-BYTE_BITS){1'b0}}, cfg.margin};
  assign mid_lo = nth_w + m_w;
  assign mid_hi = dth_w - m_w;

  assign is_day   = s_w > dth_w;
  assign is_mid   = (s_w > mid_lo) && (s_w < mid_hi);
  assign is_night = (s_w < nth_w) && !s_w[CW-1] && (|s_w);

  assign conf_w    = {1'b0, cfg.confirm};
  assign day_inc   = {1'b0, day_run_r} + 1'b1;
  assign mid_inc   = {1'b0, mid_run_r} + 1'b1;
  assign night_inc = {1'b0, night_run_r} + 1'b1;
  assign day_hit   = day_inc >= conf_w;
  assign mid_hit   = mid_inc >= conf_w;
  assign night_hit = night_inc >= conf_w;

  always_comb begin
    day_run_nxt   = day_run_r;
    mid_run_nxt   = mid_run_r;
    night_run_nxt = night_run_r;
    mode_nxt      = mode_r;
    bwr           = 1'b0;
    bval          = '0;
    if (is_day) begin
      day_run_nxt   = day_hit ? '0 : day_inc[BYTE_BITS-1:0];
      mid_run_nxt   = '0;
      night_run_nxt = '0;
      if (day_hit) begin
        mode_nxt = MODE_DAY;
        bwr      = 1'b1;
        bval     = cfg.bright_day;
      end
    end else if (is_mid) begin
      mid_run_nxt   = mid_hit ? '0 : mid_inc[BYTE_BITS-1:0];
      day_run_nxt   = '0;
      night_run_nxt = '0;
      if (mid_hit) begin
        mode_nxt = MODE_MIDDLE;
        bwr      = 1'b1;
        bval     = cfg.bright_mid;
      end
    end else if (is_night) begin
      night_run_nxt = night_hit ? '0 : night_inc[BYTE_BITS-1:0];
      day_run_nxt   = '0;
      mid_run_nxt   = '0;
      if (night_hit) begin
        mode_nxt = MODE_NIGHT;
        bwr      = 1'b1;
        bval     = cfg.bright_night;
      end
    end else begin
      mode_nxt      = MODE_INVALID;
      day_run_nxt   = '0;
      night_run_nxt = '0;
    end
  end

  assign res.mode    = mode_nxt;
  assign res.changed = mode_nxt != mode_r;
  assign res.bwr     = bwr;
  assign res.bval    = bval;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_run_r   <= '0;
      mid_run_r   <= '0;
      night_run_r <= '0;
      mode_r      <= MODE_INVALID;
    end else if (step) begin
      day_run_r   <= day_run_nxt;
      mid_run_r   <= mid_run_nxt;
      night_run_r <= night_run_nxt;
      mode_r      <= mode_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_one_run_active: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({|day_run_r, |mid_run_r, |night_run_r}) <= 1)
    else $error("more than one zone run counter active");

  a_invalid_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !is_day && !is_mid && !is_night) |=> (day_run_r == '0 && night_run_r == '0))
    else $error("invalid sample left day or night run counter set");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(mode_r) && $stable(day_run_r) && $stable(mid_run_r)
               && $stable(night_run_r)))
    else $error("tracker state moved without a step");

  a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.bwr) |=> (mode_r != MODE_INVALID))
    else $error("brightness write left mode invalid");
`endif

endmodule

FILE: design/light_mode_classifier_core.sv
// Top level of the light mode classifier: input register, zone tracker, result register.
// Depends on lmc_pkg, the three channel interfaces, lmc_cfg_regs and lmc_zone_tracker.
//
// One light sample is taken per clock cycle while ready is high. A sample is held in
// the input register, classified and counted in a single combinational pass, and its
// result is registered into the result register when that register is free or its
// result is being taken. The rate is set by that single pass through the zone compare
// and run counter update; ready falls only when both the input and the result register
// are full and the result is not being taken. The configuration port is always ready
// and takes one register write per cycle.
module light_mode_classifier_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lmc_in_if.sink     in_s,
  lmc_out_if.source  out_m,
  lmc_cfg_if.sink    cfg_s
);
  import lmc_pkg::*;

  lmc_cfg_t    cfg;
  lmc_result_t res;

  logic                          s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          out_valid_r, out_valid_nxt;
  lmc_result_t                   out_res_r;
  logic                          out_free, advance, in_take;

  assign out_free   = !out_valid_r || out_m.ready;
  assign advance    = s1_valid_r && out_free;
  assign in_s.ready = !s1_valid_r || out_free;
  assign in_take    = in_s.valid && in_s.ready;

  lmc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .cfg   (cfg)
  );

  lmc_zone_tracker #(.SAMPLE_BITS(SAMPLE_BITS)) u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_m.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= SAMPLE_BITS'(in_s.light_sample);
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_m.valid            = out_valid_r;
  assign out_m.light_mode       = out_res_r.mode;
  assign out_m.mode_changed     = out_res_r.changed;
  assign out_m.brightness_write = out_res_r.bwr;
  assign out_m.brightness_value = out_res_r.bval;

`ifndef ASSERT_OFF
  a_write_valid_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.bwr) |-> (out_res_r.mode != MODE_INVALID))
    else $error("brightness write offered with invalid mode");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.bwr) |-> (out_res_r.bval == '0))
    else $error("brightness value nonzero without a write");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_s.ready)
    else $error("input stalled while result register empty");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced transaction did not reach result register");
`endif

endmodule
